@@ rtl/ntc_thermistor_to_celsius_macros.svh @@
// ----------------------------------------------------------------------------
// NTC thermistor converter assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef NTC_THERMISTOR_TO_CELSIUS_MACROS_SVH
`define NTC_THERMISTOR_TO_CELSIUS_MACROS_SVH

// Same-cycle implication.
`define NTC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ntc_pkg.sv @@
// ----------------------------------------------------------------------------
// NTC converter package
// Widths, constants, codes and the base-2 log table shared by the design.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ntc_pkg;

  // Field and register widths.
  localparam int ADC_BITS       = 12;
  localparam int LOG_TABLE_BITS = 8;
  localparam int RES_W          = 20;
  localparam int BETA_W         = 14;
  localparam int T0_W           = 16;
  localparam int TEMP_W         = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 20;

  // Fixed-point layout of the log path.
  localparam int FRAC_BITS = 24;
  localparam int V_W       = RES_W + ADC_BITS;
  localparam int E_W       = $clog2(V_W);
  localparam int LOG_W     = E_W + FRAC_BITS + 1;
  localparam int TAB_N     = 1 << LOG_TABLE_BITS;
  localparam int TAB_W     = FRAC_BITS + 1;
  localparam int REM_BITS  = 31 - LOG_TABLE_BITS;
  localparam int LN2_W     = 30;
  localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;

  // Temperature division path.
  localparam int BASE_W  = BETA_W + 7 + FRAC_BITS;
  localparam int NUM_W   = T0_W + BETA_W + 7 + FRAC_BITS;
  localparam int DEN_W   = LOG_W + T0_W + 2;
  localparam int DSR_W   = DEN_W - 1;
  localparam int DVD_W   = NUM_W + 1;
  localparam int Q_W     = 17;
  localparam int DIV_LAT = Q_W + 1;
  localparam int TK_SAT  = 60082;
  localparam int C_OFF   = 27315;

  // Register reset values.
  localparam logic [RES_W-1:0]    RDIV_RST = 20'd100000;
  localparam logic [RES_W-1:0]    R0_RST   = 20'd100000;
  localparam logic [BETA_W-1:0]   BETA_RST = 14'd4250;
  localparam logic [T0_W-1:0]     T0_RST   = 16'd29515;
  localparam logic [ADC_BITS-1:0] FS_RST   = ADC_BITS'(4095);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RDIV = 3'd0,
    REG_R0   = 3'd1,
    REG_BETA = 3'd2,
    REG_T0   = 3'd3,
    REG_FS   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STAT_VALID = 2'd0,
    STAT_OPEN  = 2'd1,
    STAT_SHORT = 2'd2
  } status_t;

  // Control that travels alongside each item in the pipeline.
  typedef struct packed {
    logic    vld;
    status_t status;
    logic    pole;
  } side_t;

  typedef logic [TAB_W-1:0] log_tab_t [0:TAB_N];

  // log2(1 + i/2^L) in Q24 by repeated squaring in Q30, truncating each square.
  function automatic log_tab_t build_log_tab();
    log_tab_t             t;
    logic [63:0]          y;
    logic [FRAC_BITS-1:0] acc;
    for (int i = 0; i < TAB_N; i++) begin
      y   = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
      acc = '0;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        y = (y * y) >> 30;
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          acc[FRAC_BITS-k] = 1'b1;
        end
      end
      t[i] = {1'b0, acc};
    end
    t[TAB_N] = TAB_W'(1) << FRAC_BITS;
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

@@ rtl/ntc_in_if.sv @@
// ----------------------------------------------------------------------------
// NTC input channel
// Carries one ADC code per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ntc_in_if import ntc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

@@ rtl/ntc_out_if.sv @@
// ----------------------------------------------------------------------------
// NTC result channel
// Carries one temperature and status per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ntc_out_if import ntc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_centi_c;
  logic [1:0]               status;

  modport source (output valid, output temp_centi_c, output status, input ready);
  modport sink   (input valid, input temp_centi_c, input status, output ready);
endinterface

@@ rtl/ntc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// NTC configuration channel
// Register write port: index and data with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ntc_cfg_if import ntc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/ntc_thermistor_to_celsius.sv @@
// ----------------------------------------------------------------------------
// NTC thermistor to Celsius converter
// Beta-equation temperature from a divider ADC code, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one ADC code per clock cycle while not held, and gives one
// temperature item per code, in hundredths of a degree Celsius with a status
// (valid, open or shorted). An accepted item passes through twelve stages of
// resistance, logarithm and denominator arithmetic, the 18-stage quotient
// pipeline (an overflow check and one restoring stage per quotient bit), then
// the result buffer, before it appears on the result channel.
// A two-entry result buffer lets the pipeline keep taking items while a result
// waits, and the whole pipeline holds only when both entries are full.
// Registers are to be written by the user only while no item is in flight; the
// block does not enforce this. Derived constants are registered from them.
`timescale 1ns / 1ps

`include "ntc_thermistor_to_celsius_macros.svh"

module ntc_thermistor_to_celsius import ntc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ntc_in_if.sink     in_if,
  ntc_out_if.source  out_if,
  ntc_cfg_if.sink    cfg_if
);

  localparam int SIDE_N = 12 + DIV_LAT;

  // Configuration registers and derived constants.
  logic [RES_W-1:0]    rdiv_r, r0_r;
  logic [BETA_W-1:0]   beta_r;
  logic [T0_W-1:0]     t0_r;
  logic [ADC_BITS-1:0] fs_r;
  logic [RES_W-1:0]    rdiv_eff, r0_eff;
  logic [BETA_W-1:0]   beta_eff;
  logic [T0_W-1:0]     t0_eff;
  logic [T0_W+BETA_W-1:0] tb_r;
  logic [BASE_W-1:0]   base_cfg_r;
  logic [NUM_W-1:0]    num_cfg_r;
  logic [NUM_W-FRAC_BITS-1:0] tb100;

  // Pipeline control and payload.
  logic                     en;
  side_t                    side_r   [1:SIDE_N];
  side_t                    side_nxt [1:SIDE_N];
  status_t                  st2;
  logic [ADC_BITS-1:0]      code1_r;
  logic [V_W-1:0]           numr2_r, denr2_r;
  logic [LOG_W-1:0]         logn6, logd6;
  logic signed [LOG_W:0]    d7;
  logic [LOG_W-1:0]         mag7_r;
  logic                     neg7_r, neg8_r;
  logic [LOG_W+LN2_W-1:0]   lnp8_r, lnr9;
  logic signed [LOG_W:0]    lnq9_r;
  logic [LOG_W-1:0]         lnm9;
  logic signed [T0_W:0]     t0s;
  logic signed [DEN_W-1:0]  tl10_r, den11_r;
  logic [DVD_W-1:0]         dvd12_r;
  logic [DSR_W-1:0]         dsr12_r;
  logic [Q_W-1:0]           quo;
  logic                     ovf;
  logic signed [Q_W:0]      tc;
  logic signed [TEMP_W-1:0] temp_fin;

  // Result buffer.
  logic                     push, pop;
  logic [1:0]               cnt_r;
  logic                     wr_ptr_r, rd_ptr_r;
  logic signed [TEMP_W-1:0] buf_temp_r [0:1];
  status_t                  buf_stat_r [0:1];

  // Register writes; indexes beyond the list are dropped.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdiv_r <= RDIV_RST;
      r0_r   <= R0_RST;
      beta_r <= BETA_RST;
      t0_r   <= T0_RST;
      fs_r   <= FS_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_RDIV: rdiv_r <= cfg_if.data[RES_W-1:0];
        REG_R0:   r0_r   <= cfg_if.data[RES_W-1:0];
        REG_BETA: beta_r <= cfg_if.data[BETA_W-1:0];
        REG_T0:   t0_r   <= cfg_if.data[T0_W-1:0];
        REG_FS:   fs_r   <= cfg_if.data[ADC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A zero register value is taken as one.
  assign rdiv_eff = (rdiv_r == '0) ? RES_W'(1) : rdiv_r;
  assign r0_eff   = (r0_r == '0) ? RES_W'(1) : r0_r;
  assign beta_eff = (beta_r == '0) ? BETA_W'(1) : beta_r;
  assign t0_eff   = (t0_r == '0) ? T0_W'(1) : t0_r;
  assign tb100    = (NUM_W-FRAC_BITS)'(tb_r) * (NUM_W-FRAC_BITS)'(100);

  // Constant numerator 100*T0*B and denominator base 100*B, both scaled by 2^24.
  always_ff @(posedge clk) begin
    tb_r       <= (T0_W+BETA_W)'(t0_eff) * (T0_W+BETA_W)'(beta_eff);
    num_cfg_r  <= {tb100, {FRAC_BITS{1'b0}}};
    base_cfg_r <= {(BASE_W-FRAC_BITS)'(beta_eff) * (BASE_W-FRAC_BITS)'(100),
                   {FRAC_BITS{1'b0}}};
  end

  // The pipeline moves unless the result buffer is full.
  assign en          = (cnt_r != 2'd2);
  assign in_if.ready = en;

  // Classification of the code against the rails.
  always_comb begin
    if (code1_r == '0) begin
      st2 = STAT_OPEN;
    end else if (code1_r >= fs_r) begin
      st2 = STAT_SHORT;
    end else begin
      st2 = STAT_VALID;
    end
  end

  // Control travelling with each item.
  always_comb begin
    side_nxt[1] = '{vld: in_if.valid, status: STAT_VALID, pole: 1'b0};
    for (int s = 2; s <= SIDE_N; s++) begin
      side_nxt[s] = side_r[s-1];
    end
    side_nxt[2].status = st2;
    side_nxt[12].pole  = den11_r[DEN_W-1] || (den11_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= SIDE_N; s++) begin
        side_r[s] <= '0;
      end
    end else if (en) begin
      side_r <= side_nxt;
    end
  end

  // Divider resistance product and thermistor product.
  always_ff @(posedge clk) begin
    if (en) begin
      code1_r <= in_if.adc_code;
      numr2_r <= V_W'(rdiv_eff) * V_W'(fs_r - code1_r);
      denr2_r <= V_W'(code1_r) * V_W'(r0_eff);
    end
  end

  ntc_log2 u_log_num (.clk(clk), .en(en), .v_in(numr2_r), .log_out(logn6));
  ntc_log2 u_log_den (.clk(clk), .en(en), .v_in(denr2_r), .log_out(logd6));

  // Log ratio, conversion to natural log with rounding half away from zero.
  assign d7   = $signed({1'b0, logn6}) - $signed({1'b0, logd6});
  assign lnr9 = lnp8_r + (LOG_W+LN2_W)'(64'd1 << 29);
  assign lnm9 = lnr9[LOG_W+29:30];
  assign t0s  = $signed({1'b0, t0_eff});

  always_ff @(posedge clk) begin
    if (en) begin
      neg7_r  <= d7[LOG_W];
      mag7_r  <= d7[LOG_W] ? LOG_W'(-d7) : LOG_W'(d7);
      neg8_r  <= neg7_r;
      lnp8_r  <= (LOG_W+LN2_W)'(mag7_r) * (LOG_W+LN2_W)'(LN2_Q30);
      lnq9_r  <= neg8_r ? -$signed({1'b0, lnm9}) : $signed({1'b0, lnm9});
      tl10_r  <= t0s * lnq9_r;
      den11_r <= $signed({{(DEN_W-BASE_W){1'b0}}, base_cfg_r}) + tl10_r;
      dsr12_r <= den11_r[DSR_W-1:0];
      dvd12_r <= DVD_W'(num_cfg_r) + DVD_W'(den11_r[DSR_W-1:1]);
    end
  end

  ntc_div u_div (
    .clk (clk),
    .en  (en),
    .dvd (dvd12_r),
    .dsr (dsr12_r),
    .quo (quo),
    .ovf (ovf)
  );

  // Kelvin to Celsius with saturation and the special cases.
  assign tc = $signed({1'b0, quo}) - $signed((Q_W+1)'(C_OFF));

  always_comb begin
    if (side_r[SIDE_N].status == STAT_OPEN) begin
      temp_fin = -16'sd32768;
    end else if (side_r[SIDE_N].status == STAT_SHORT || side_r[SIDE_N].pole || ovf ||
                 quo >= Q_W'(TK_SAT)) begin
      temp_fin = 16'sd32767;
    end else begin
      temp_fin = tc[TEMP_W-1:0];
    end
  end

  // Two-entry result buffer.
  assign push = en && side_r[SIDE_N].vld;
  assign pop  = out_if.valid && out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_temp_r[wr_ptr_r] <= temp_fin;
      buf_stat_r[wr_ptr_r] <= side_r[SIDE_N].status;
    end
  end

  assign out_if.valid        = (cnt_r != 2'd0);
  assign out_if.temp_centi_c = buf_temp_r[rd_ptr_r];
  assign out_if.status       = buf_stat_r[rd_ptr_r];

  // Checks on buffer occupancy, special-case results and item flow.
  `NTC_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r != 2'd3, "result buffer overfilled")
  `NTC_ASSERT_IMPL(a_open_temp, out_if.valid && out_if.status == STAT_OPEN, out_if.temp_centi_c == -16'sd32768, "open item without minimum temperature")
  `NTC_ASSERT_IMPL(a_short_temp, out_if.valid && out_if.status == STAT_SHORT, out_if.temp_centi_c == 16'sd32767, "shorted item without maximum temperature")
  `NTC_ASSERT_NEXT(a_flow, en && side_r[1].vld, side_r[2].vld, "item lost between first stages")

endmodule

@@ rtl/ntc_log2.sv @@
// ----------------------------------------------------------------------------
// NTC base-2 logarithm
// Four-stage pipelined log2 in Q24: normalise, table look-up, interpolate, sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntc_log2 import ntc_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [V_W-1:0]   v_in,
  output logic [LOG_W-1:0] log_out
);

  logic [E_W-1:0]            e;
  logic [V_W+30:0]           norm;
  logic [30:0]               frac;
  logic [E_W-1:0]            e1_r, e2_r, e3_r;
  logic [LOG_TABLE_BITS:0]   idx1_r;
  logic [REM_BITS-1:0]       rem1_r, rem2_r;
  logic [TAB_W-1:0]          lo2_r, diff2_r, lo3_r;
  logic [TAB_W+REM_BITS-1:0] prod3_r;
  logic [LOG_W-1:0]          log4_r;

  // Leading-one position and normalisation so that the leading one drops off.
  always_comb begin
    e = '0;
    for (int i = 0; i < V_W; i++) begin
      if (v_in[i]) begin
        e = E_W'(i);
      end
    end
    norm = {v_in, 31'b0} << (E_W'(V_W - 1) - e);
    frac = norm[V_W+29 -: 31];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: exponent, table index and interpolation remainder.
      e1_r   <= e;
      idx1_r <= {1'b0, frac[30 -: LOG_TABLE_BITS]};
      rem1_r <= frac[REM_BITS-1:0];
      // Stage 2: neighbouring table entries.
      e2_r    <= e1_r;
      rem2_r  <= rem1_r;
      lo2_r   <= LOG_TAB[idx1_r];
      diff2_r <= LOG_TAB[idx1_r + 1'b1] - LOG_TAB[idx1_r];
      // Stage 3: interpolation product.
      e3_r    <= e2_r;
      lo3_r   <= lo2_r;
      prod3_r <= (TAB_W+REM_BITS)'(diff2_r) * (TAB_W+REM_BITS)'(rem2_r);
      // Stage 4: integer part plus fraction.
      log4_r  <= (LOG_W'(e3_r) << FRAC_BITS) + LOG_W'(lo3_r) +
                 LOG_W'(prod3_r >> REM_BITS);
    end
  end

  assign log_out = log4_r;

endmodule

@@ rtl/ntc_div.sv @@
// ----------------------------------------------------------------------------
// NTC quotient pipeline
// Restoring division, one quotient bit per stage, with an overflow check up front.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntc_div import ntc_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DVD_W-1:0] dvd,
  input  logic [DSR_W-1:0] dsr,
  output logic [Q_W-1:0]   quo,
  output logic             ovf
);

  localparam int REM_W = DSR_W + Q_W;

  logic [REM_W-1:0] rem_r [0:Q_W];
  logic [DSR_W-1:0] dsr_r [0:Q_W];
  logic [Q_W-1:0]   quo_r [0:Q_W];
  logic             ovf_r [0:Q_W];

  // Entry stage: a quotient that needs more than Q_W bits is flagged as overflow.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= REM_W'(dvd);
      dsr_r[0] <= dsr;
      quo_r[0] <= '0;
      ovf_r[0] <= REM_W'(dvd) >= (REM_W'(dsr) << Q_W);
    end
  end

  // One trial subtraction per stage, most significant bit first.
  for (genvar j = 1; j <= Q_W; j++) begin : g_step
    logic [REM_W-1:0] sh;
    logic             ge;
    assign sh = REM_W'(dsr_r[j-1]) << (Q_W - j);
    assign ge = rem_r[j-1] >= sh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? rem_r[j-1] - sh : rem_r[j-1];
        dsr_r[j] <= dsr_r[j-1];
        quo_r[j] <= {quo_r[j-1][Q_W-2:0], ge};
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  assign quo = quo_r[Q_W];
  assign ovf = ovf_r[Q_W];

endmodule

@@ tb/sv/ntc_thermistor_to_celsius_tb.sv @@
// ----------------------------------------------------------------------------
// NTC thermistor converter testbench
// Drives ADC codes through the converter under several register settings.
// Each result's temperature and status is checked against a bit-exact
// beta-equation predictor. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntc_thermistor_to_celsius_tb;
  import ntc_pkg::*;

  localparam int  WATCHDOG_LIMIT = 4000;
  localparam int  DRAIN_CYCLES   = 40;
  localparam int  HOLD_CYCLES    = 300;
  localparam int  CENTI_OFFSET   = 27315;
  localparam longint unsigned LN2_Q30_C = 64'd744261118;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    status_t                  status;
  } temp_item_t;

  logic clk;
  logic rst_n;

  ntc_in_if  in_ch ();
  ntc_out_if out_ch ();
  ntc_cfg_if cfg_ch ();

  ntc_thermistor_to_celsius u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Clock: 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register copies used by the predictor.
  logic [RES_W-1:0]    rdiv_q;
  logic [RES_W-1:0]    r0_q;
  logic [BETA_W-1:0]   beta_q;
  logic [T0_W-1:0]     t0_q;
  logic [ADC_BITS-1:0] fs_q;

  logic [31:0]         log2_frac [0:TAB_N];
  logic [ADC_BITS-1:0] code_q [$];
  temp_item_t          temp_q [$];

  int errors, n_sent, n_checked, n_open, n_short, n_valid, n_pegged;
  int src_gap, snk_gap, hold_left, hold_req, hold_seen, idle_cycles;
  bit steady;

  // Fractional log2 table, truncating squares in Q30.
  function automatic void build_log2_frac();
    logic [63:0] y;
    logic [31:0] acc;
    for (int i = 0; i < TAB_N; i++) begin
      y   = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
      acc = '0;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        y = (y * y) >> 30;
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          acc = acc | (32'd1 << (FRAC_BITS - k));
        end
      end
      log2_frac[i] = acc;
    end
    log2_frac[TAB_N] = 32'd1 << FRAC_BITS;
  endfunction

  // log2 of a positive integer in Q24 with linear interpolation.
  function automatic longint unsigned log2_q24(longint unsigned v);
    int e;
    longint unsigned m, f, idx, rem, lo, hi;
    e = 63;
    while (e > 0 && v[e] == 1'b0) e--;
    m   = (e >= 31) ? (v >> (e - 31)) : (v << (31 - e));
    f   = m & 64'h7FFF_FFFF;
    idx = f >> REM_BITS;
    rem = f & ((64'd1 << REM_BITS) - 1);
    lo  = log2_frac[idx];
    hi  = log2_frac[idx + 1];
    return (64'(e) << FRAC_BITS) + lo + (((hi - lo) * rem) >> REM_BITS);
  endfunction

  // Temperature and status expected for one ADC code.
  function automatic temp_item_t predict_temp(logic [ADC_BITS-1:0] code);
    temp_item_t      r;
    longint unsigned rd, r0, b, t0, mag, num, ud, tk;
    longint          d, lnq, den, c;
    rd = (rdiv_q == 0) ? 1 : rdiv_q;
    r0 = (r0_q == 0) ? 1 : r0_q;
    b  = (beta_q == 0) ? 1 : beta_q;
    t0 = (t0_q == 0) ? 1 : t0_q;
    r.status = STAT_VALID;
    if (code == 0) begin
      r.status = STAT_OPEN;
      r.temp   = -16'sd32768;
    end else if (code >= fs_q) begin
      r.status = STAT_SHORT;
      r.temp   = 16'sd32767;
    end else begin
      d   = longint'(log2_q24(rd * (fs_q - code))) - longint'(log2_q24(64'(code) * r0));
      mag = (d < 0) ? -d : d;
      lnq = longint'((mag * LN2_Q30_C + (64'd1 << 29)) >> 30);
      if (d < 0) lnq = -lnq;
      den = longint'(100 * b * (64'd1 << FRAC_BITS)) + longint'(t0) * lnq;
      if (den <= 0) begin
        r.temp = 16'sd32767;
      end else begin
        num = 100 * t0 * b * (64'd1 << FRAC_BITS);
        ud  = den;
        tk  = (num + ud / 2) / ud;
        if (tk >= CENTI_OFFSET + 32767) begin
          r.temp = 16'sd32767;
        end else begin
          c = longint'(tk) - CENTI_OFFSET;
          r.temp = (c < -32768) ? -16'sd32768 : 16'(c);
        end
      end
    end
    return r;
  endfunction

  // Gap lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Codes weighted towards open, shorted and near full scale.
  function automatic logic [ADC_BITS-1:0] pick_code();
    int r;
    int unsigned k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 3);
    if (r < 6) return '0;
    if (r < 14) return (fs_q + k > 4095) ? 12'd4095 : ADC_BITS'(fs_q + k);
    if (r < 26 && fs_q > k + 1) return ADC_BITS'(fs_q - 1 - k);
    if (r < 34) return ADC_BITS'($urandom_range(1, 16));
    return ADC_BITS'($urandom_range(0, 4095));
  endfunction

  // Source side: offers queued codes and records each accepted item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        temp_q.push_back(predict_temp(in_ch.adc_code));
        src_gap = pick_gap();
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the offered item until it is taken.
      end else if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (code_q.size() > 0) begin
        in_ch.valid    <= 1'b1;
        in_ch.adc_code <= code_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Sink side: random stalls, long hold-offs on request, and the check.
  always @(posedge clk) begin
    temp_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (temp_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: temp %0d status %0d",
                   $time, out_ch.temp_centi_c, out_ch.status);
        end else begin
          want = temp_q.pop_front();
          n_checked++;
          case (want.status)
            STAT_OPEN:  n_open++;
            STAT_SHORT: n_short++;
            default:    n_valid++;
          endcase
          if (want.status == STAT_VALID && want.temp == 16'sd32767) n_pegged++;
          if (out_ch.temp_centi_c !== want.temp) begin
            errors++;
            $display("%0t: temp_centi_c mismatch: expected %0d, got %0d",
                     $time, want.temp, out_ch.temp_centi_c);
          end
          if (out_ch.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, out_ch.status);
          end
        end
        snk_gap = pick_gap();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which no channel moves an item.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $time, idle_cycles);
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // One register write; called at a clock edge, leaves valid high.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_RDIV: rdiv_q = data[RES_W-1:0];
      REG_R0:   r0_q   = data[RES_W-1:0];
      REG_BETA: beta_q = data[BETA_W-1:0];
      REG_T0:   t0_q   = data[T0_W-1:0];
      REG_FS:   fs_q   = data[ADC_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [19:0] rd, logic [19:0] r0, logic [19:0] b,
                         logic [19:0] t0, logic [19:0] fs);
    cfg_write(REG_RDIV, rd);
    cfg_write(REG_R0, r0);
    cfg_write(REG_BETA, b);
    cfg_write(REG_T0, t0);
    cfg_write(REG_FS, fs);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) code_q.push_back(pick_code());
    n_sent += n;
  endtask

  // Wait until every queued item has gone in and every result has come out.
  task automatic drain();
    do @(posedge clk); while (code_q.size() > 0 || in_ch.valid || temp_q.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  logic [ADC_BITS-1:0] directed_codes [$] = '{
    12'd0, 12'd1, 12'd2, 12'd3, 12'd7, 12'd100, 12'd1024, 12'd2047, 12'd2048,
    12'hAAA, 12'h555, 12'd3000, 12'd4000, 12'd4093, 12'd4094, 12'd4095, 12'h800
  };

  // Test sequence.
  initial begin
    build_log2_frac();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.adc_code = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_RDIV;
    cfg_ch.data = '0;
    rdiv_q = RDIV_RST; r0_q = R0_RST; beta_q = BETA_RST; t0_q = T0_RST; fs_q = FS_RST;
    errors = 0; n_sent = 0; n_checked = 0;
    n_open = 0; n_short = 0; n_valid = 0; n_pegged = 0;
    src_gap = 0; snk_gap = 0; hold_left = 0; hold_req = 0; hold_seen = 0;
    idle_cycles = 0; steady = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, with writes to unused indexes that must change nothing.
    cfg_write(REG_SPARE_LO, 20'hFFFFF);
    cfg_write(REG_SPARE_HI, 20'h12345);
    cfg_all(20'd100000, 20'd100000, 20'd4250, 20'd29515, 20'd4095);
    foreach (directed_codes[i]) code_q.push_back(directed_codes[i]);
    n_sent += directed_codes.size();
    hold_req++;
    queue_random(200);
    drain();

    // Largest B, T0 and R0 with the smallest divider: runs into the pole.
    steady = 1'b1;
    cfg_all(20'd1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    code_q.push_back(12'd4094);
    code_q.push_back(12'd1);
    n_sent += 2;
    queue_random(120);
    drain();
    steady = 1'b0;

    // Opposite extremes: full scale of one leaves almost everything shorted.
    cfg_all(20'hFFFFF, 20'd1, 20'd1, 20'd1, 20'd1);
    queue_random(60);
    drain();

    // Zero registers stand in for one; then a zero full scale.
    cfg_all(20'd0, 20'd0, 20'd0, 20'd0, 20'd4095);
    code_q.push_back(12'd1);
    code_q.push_back(12'd4094);
    n_sent += 2;
    queue_random(60);
    drain();
    cfg_all(20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
    queue_random(40);
    drain();

    // Random settings, full 20-bit data so upper bits must be dropped.
    for (int p = 0; p < 7; p++) begin
      cfg_all(20'($urandom), 20'($urandom), ($urandom_range(0, 3) == 0) ?
              20'($urandom_range(1000, 6000)) : 20'($urandom),
              20'($urandom_range(20000, 40000)), ($urandom_range(0, 2) == 0) ?
              20'($urandom) : 20'($urandom_range(3000, 4095)));
      if (p == 3) hold_req++;
      queue_random(110);
      drain();
    end

    $display("Checked %0d of %0d items under 12 register settings: %0d in range,",
             n_checked, n_sent, n_valid);
    $display("%0d open, %0d shorted, %0d at the upper limit; %0d mismatches.",
             n_open, n_short, n_pegged, errors);
    if (errors == 0 && temp_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ntc_pkg.sv
rtl/ntc_in_if.sv
rtl/ntc_out_if.sv
rtl/ntc_cfg_if.sv
rtl/ntc_log2.sv
rtl/ntc_div.sv
rtl/ntc_thermistor_to_celsius.sv
tb/sv/ntc_thermistor_to_celsius_tb.sv
